// ----- rtl/dtf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types, codes and helpers for the double to foreign float converter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  // Target format codes.
  typedef enum logic [2:0] {
    FMT_IEEE_SINGLE = 3'd0,
    FMT_IEEE_DOUBLE = 3'd1,
    FMT_IBM_SINGLE  = 3'd2,
    FMT_IBM_DOUBLE  = 3'd3,
    FMT_VAX_F       = 3'd4
  } fmt_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  localparam int FracW = 52;
  localparam int MantW = 53;
  localparam int ExpW  = 13;

  // Normalized word handed from the front end to the format stage.
  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic                   inf;
    logic                   sign;
    logic signed [ExpW-1:0] ue;
    logic [MantW-1:0]       mant;
  } norm_t;

  // Index of the highest set bit of a nonzero fraction.
  function automatic logic [5:0] top_bit(input logic [FracW-1:0] f);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < FracW; i++) begin
      if (f[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/dtf_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_norm
// Two-stage front end: decodes the double, finds the leading one of a
// subnormal fraction, then normalizes the mantissa and unbiases the exponent.
// ----------------------------------------------------------------------------
module dtf_norm import dtf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] in_word,
  output norm_t       norm_o
);

  // Stage one registers.
  logic             v1_r, v1_nxt;
  logic             sign1_r, zero1_r, inf1_r, sub1_r;
  logic [10:0]      be1_r;
  logic [FracW-1:0] frac1_r;
  logic [5:0]       top1_r;

  // Stage two register.
  norm_t n2_r, n2_nxt;

  assign v1_nxt = in_valid;

  // Decode fields and locate the leading one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
    sign1_r <= in_word[63];
    be1_r   <= in_word[62:52];
    frac1_r <= in_word[51:0];
    zero1_r <= (in_word[62:52] == 11'd0) && (in_word[51:0] == '0);
    inf1_r  <= (in_word[62:52] == 11'h7FF);
    sub1_r  <= (in_word[62:52] == 11'd0);
    top1_r  <= top_bit(in_word[51:0]);
  end

  // Normalize: subnormals shift their leading one up to the hidden position.
  always_comb begin
    n2_nxt       = '0;
    n2_nxt.valid = v1_r;
    n2_nxt.zero  = zero1_r;
    n2_nxt.inf   = inf1_r;
    n2_nxt.sign  = sign1_r;
    if (sub1_r) begin
      n2_nxt.mant = {1'b0, frac1_r} << (6'd52 - top1_r);
      n2_nxt.ue   = $signed({7'd0, top1_r}) - 13'sd1074;
    end else begin
      n2_nxt.mant = {1'b1, frac1_r};
      n2_nxt.ue   = $signed({2'd0, be1_r}) - 13'sd1023;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_r.valid <= 1'b0;
    end else begin
      n2_r.valid <= n2_nxt.valid;
    end
    n2_r.zero <= n2_nxt.zero;
    n2_r.inf  <= n2_nxt.inf;
    n2_r.sign <= n2_nxt.sign;
    n2_r.ue   <= n2_nxt.ue;
    n2_r.mant <= n2_nxt.mant;
  end

  assign norm_o = n2_r;

endmodule

// ----- rtl/double_to_foreign_float_fields.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_foreign_float_fields
// Converts an IEEE double into IEEE single/double, IBM hex or VAX F fields.
// ----------------------------------------------------------------------------
// A word is taken on every cycle that start is high; busy stays low. Each
// result appears on the out_ ports after the three register stages, for
// one cycle marked by out_valid, and must be captured then. The stages are
// decode with leading-one search, normalize, and format selection with
// range clamping. The user is to write the target format through
// cfg_valid/cfg_data only while no word is in flight; the block itself does
// not enforce this. Codes above four are ignored.
module double_to_foreign_float_fields import dtf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_double_bits,
  output logic        out_valid,
  output logic        out_sign,
  output logic [10:0] out_exponent,
  output logic [23:0] out_frac_high,
  output logic [31:0] out_frac_low,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  fmt_t  fmt_r;
  norm_t nrm;

  logic        v3_r;
  logic        sign3_r, sign3_nxt;
  logic [10:0] exp3_r, exp3_nxt;
  logic [23:0] fh3_r, fh3_nxt;
  logic [31:0] fl3_r, fl3_nxt;
  status_t     st3_r, st3_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Format register; unused codes leave it unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_IEEE_DOUBLE;
    end else if (cfg_valid && cfg_data <= 3'd4) begin
      fmt_r <= fmt_t'(cfg_data);
    end
  end

  dtf_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_word  (in_double_bits),
    .norm_o   (nrm)
  );

  // Format stage: bias, fraction select and clamping.
  always_comb begin
    logic signed [ExpW-1:0] e, lo_e, hi_e, k;
    logic [55:0]            m56;
    logic [23:0]            fh, fh_max, fh_min;
    logic [31:0]            fl, fl_max;
    e = '0; lo_e = 13'sd1; hi_e = 13'sd2046;
    fh = '0; fl = '0; fh_max = '0; fl_max = '0; fh_min = '0;
    k   = (nrm.ue + 13'sd4) >>> 2;
    m56 = {3'd0, nrm.mant} << nrm.ue[1:0];
    unique case (fmt_r)
      FMT_IEEE_SINGLE: begin
        e = nrm.ue + 13'sd127; hi_e = 13'sd254;
        fh = {1'b0, nrm.mant[51:29]}; fh_max = 24'h7FFFFF;
      end
      FMT_IBM_SINGLE: begin
        e = k + 13'sd64; lo_e = 13'sd0; hi_e = 13'sd127;
        fh = m56[55:32]; fh_max = 24'hFFFFFF; fh_min = 24'h100000;
      end
      FMT_IBM_DOUBLE: begin
        e = k + 13'sd64; lo_e = 13'sd0; hi_e = 13'sd127;
        fh = m56[55:32]; fl = m56[31:0];
        fh_max = 24'hFFFFFF; fl_max = 32'hFFFFFFFF; fh_min = 24'h100000;
      end
      FMT_VAX_F: begin
        e = nrm.ue + 13'sd129; hi_e = 13'sd255;
        fh = {1'b0, nrm.mant[51:29]}; fh_max = 24'h7FFFFF;
      end
      default: begin
        e = nrm.ue + 13'sd1023;
        fh = {4'd0, nrm.mant[51:32]}; fl = nrm.mant[31:0];
        fh_max = 24'h0FFFFF; fl_max = 32'hFFFFFFFF;
      end
    endcase
    sign3_nxt = nrm.sign;
    exp3_nxt  = e[10:0];
    fh3_nxt   = fh;
    fl3_nxt   = fl;
    st3_nxt   = ST_OK;
    priority if (nrm.zero) begin
      sign3_nxt = 1'b0; exp3_nxt = '0; fh3_nxt = '0; fl3_nxt = '0;
      st3_nxt = ST_ZERO;
    end else if (nrm.inf || e > hi_e) begin
      exp3_nxt = hi_e[10:0]; fh3_nxt = fh_max; fl3_nxt = fl_max;
      st3_nxt = ST_OVERFLOW;
    end else if (e < lo_e) begin
      exp3_nxt = lo_e[10:0]; fh3_nxt = fh_min; fl3_nxt = '0;
      st3_nxt = ST_UNDERFLOW;
    end else begin
      st3_nxt = ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= nrm.valid;
    end
    sign3_r <= sign3_nxt;
    exp3_r  <= exp3_nxt;
    fh3_r   <= fh3_nxt;
    fl3_r   <= fl3_nxt;
    st3_r   <= st3_nxt;
  end

  assign out_valid     = v3_r;
  assign out_sign      = sign3_r;
  assign out_exponent  = exp3_r;
  assign out_frac_high = fh3_r;
  assign out_frac_low  = fl3_r;
  assign out_status    = st3_r;

  // Checks on the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
    |-> out_valid) else $error("result lost in pipeline");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |-> !out_sign && out_exponent == 11'd0)
    else $error("zero result not cleared");
  a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    fmt_r <= FMT_VAX_F) else $error("format register out of range");
  a_single_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (fmt_r == FMT_IEEE_SINGLE || fmt_r == FMT_VAX_F
      || fmt_r == FMT_IBM_SINGLE) |-> out_frac_low == 32'd0)
    else $error("single target with nonzero low word");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for double_to_foreign_float_fields
// Drives IEEE double words through every target format, predicts the sign,
// exponent, fraction words and status of each result and compares them with
// the strobed outputs. A short table of directed words comes first, then
// random words biased toward the range edges of each format.
// ----------------------------------------------------------------------------
module testbench import dtf_pkg::*; ();

  // Expected fields of one result word.
  typedef struct {
    logic        sign;
    logic [10:0] exponent;
    logic [23:0] frac_high;
    logic [31:0] frac_low;
    logic [1:0]  status;
  } conv_word_t;

  // One row of the directed table.
  typedef struct {
    logic [63:0] bits;
    logic        typed;
    conv_word_t  want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_double_bits;
  logic        out_valid;
  logic        out_sign;
  logic [10:0] out_exponent;
  logic [23:0] out_frac_high;
  logic [31:0] out_frac_low;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;

  fmt_t       cur_fmt;
  conv_word_t pending_words[$];
  int         errors;
  bit         calm;

  double_to_foreign_float_fields i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_double_bits(in_double_bits), .out_valid(out_valid),
    .out_sign(out_sign), .out_exponent(out_exponent),
    .out_frac_high(out_frac_high), .out_frac_low(out_frac_low),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic conv_word_t mk(logic s, int e, logic [23:0] h, logic [31:0] l,
                                    status_t st);
    conv_word_t w;
    w.sign = s; w.exponent = 11'(e); w.frac_high = h; w.frac_low = l; w.status = st;
    return w;
  endfunction

  // Converts one double into the fields of the current target format.
  function automatic conv_word_t convert_double(logic [63:0] x, fmt_t f);
    logic        s;
    logic [10:0] be;
    logic [52:0] mant;
    logic [55:0] m56;
    int          ue, e, k, sh;
    logic        inf;
    s = x[63];
    be = x[62:52];
    inf = (be == 11'h7FF);
    if (x[62:0] == 63'd0) return mk(1'b0, 0, '0, '0, ST_ZERO);
    if (be == 0) begin
      mant = {1'b0, x[51:0]};
      ue = -1022;
      while (!mant[52]) begin
        mant = mant << 1;
        ue--;
      end
    end else begin
      mant = {1'b1, x[51:0]};
      ue = int'(be) - 1023;
    end
    case (f)
      FMT_IEEE_SINGLE: begin
        e = ue + 127;
        if (inf || e > 254) return mk(s, 254, 24'h7FFFFF, 0, ST_OVERFLOW);
        if (e < 1) return mk(s, 1, 0, 0, ST_UNDERFLOW);
        return mk(s, e, {1'b0, mant[51:29]}, 0, ST_OK);
      end
      FMT_IBM_SINGLE, FMT_IBM_DOUBLE: begin
        k = ((ue + 1 + 3 + 1600) / 4) - 400;
        sh = 4 * k - (ue + 1);
        e = 64 + k;
        if (inf || e > 127)
          return mk(s, 127, 24'hFFFFFF, (f == FMT_IBM_DOUBLE) ? 32'hFFFFFFFF : 0,
                    ST_OVERFLOW);
        if (e < 0) return mk(s, 0, 24'h100000, 0, ST_UNDERFLOW);
        if (f == FMT_IBM_SINGLE) return mk(s, e, 24'(mant >> (29 + sh)), 0, ST_OK);
        m56 = 56'(mant) << (3 - sh);
        return mk(s, e, m56[55:32], m56[31:0], ST_OK);
      end
      FMT_VAX_F: begin
        e = ue + 129;
        if (inf || e > 255) return mk(s, 255, 24'h7FFFFF, 0, ST_OVERFLOW);
        if (e < 1) return mk(s, 1, 0, 0, ST_UNDERFLOW);
        return mk(s, e, {1'b0, mant[51:29]}, 0, ST_OK);
      end
      default: begin
        e = ue + 1023;
        if (inf || e > 2046) return mk(s, 2046, 24'hFFFFF, 32'hFFFFFFFF, ST_OVERFLOW);
        if (e < 1) return mk(s, 1, 0, 0, ST_UNDERFLOW);
        return mk(s, e, {4'd0, mant[51:32]}, mant[31:0], ST_OK);
      end
    endcase
  endfunction

  // Result checker: every strobed word is compared with the oldest expectation.
  always @(posedge clk) begin
    conv_word_t w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (out_sign !== w.sign) begin
          $error("sign: expected %0h, got %0h", w.sign, out_sign); errors++;
        end
        if (out_exponent !== w.exponent) begin
          $error("exponent: expected %0h, got %0h", w.exponent, out_exponent); errors++;
        end
        if (out_frac_high !== w.frac_high) begin
          $error("frac_high: expected %0h, got %0h", w.frac_high, out_frac_high);
          errors++;
        end
        if (out_frac_low !== w.frac_low) begin
          $error("frac_low: expected %0h, got %0h", w.frac_low, out_frac_low); errors++;
        end
        if (out_status !== w.status) begin
          $error("status: expected %0h, got %0h", w.status, out_status); errors++;
        end
      end
    end
  end

  // Sends one word, with random gaps unless in a calm stretch. Start stays
  // high afterwards so that the next word can follow in the very next cycle.
  task automatic send_word(logic [63:0] bits, conv_word_t want);
    while (!calm && $urandom_range(99) < 15) begin
      start <= 1'b0;
      in_double_bits <= {$urandom, $urandom};
      @(posedge clk);
    end
    start <= 1'b1;
    in_double_bits <= bits;
    do @(posedge clk); while (busy);
    pending_words.push_back(want);
  endtask

  task automatic send_predicted(logic [63:0] bits);
    send_word(bits, convert_double(bits, cur_fmt));
  endtask

  // Stops sending and waits for all results to drain.
  task automatic drain;
    int n;
    n = 0;
    start <= 1'b0;
    while (pending_words.size() != 0 && n < 10000) begin
      @(posedge clk);
      n++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Writes the format register; illegal codes leave it unchanged.
  task automatic write_format(logic [2:0] code);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (code <= 3'd4) cur_fmt = fmt_t'(code);
  endtask

  // Random double biased toward the exponent edges of the formats.
  function automatic logic [63:0] pick_double();
    logic [63:0] x;
    int          r;
    x = {$urandom, $urandom};
    r = $urandom_range(9);
    case (r)
      0: x[62:52] = 11'd0;
      1: x[62:52] = 11'h7FF;
      2: x[62:52] = 11'(1023 + $urandom_range(0, 260) - 130);
      3: x[62:52] = 11'(1023 + $urandom_range(0, 600) - 300);
      4: x[62:52] = $urandom_range(1) ? 11'd1 : 11'd2046;
      5: begin x[62:52] = 11'd0; x[51:0] = 52'd1 << $urandom_range(51); end
      default: ;
    endcase
    return x;
  endfunction

  stim_row_t table_rows[$];

  initial begin
    stim_row_t   r;
    logic [2:0]  codes[7];
    errors = 0;
    calm = 1'b0;
    cur_fmt = FMT_IEEE_DOUBLE;
    rst_n = 1'b0; start = 1'b0; in_double_bits = '0; cfg_valid = 1'b0; cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table in the reset format (IEEE double).
    r.typed = 1;
    r.bits = 64'h0; r.want = mk(0, 0, 0, 0, ST_ZERO); table_rows.push_back(r);
    r.bits = 64'h8000000000000000; r.want = mk(0, 0, 0, 0, ST_ZERO);
    table_rows.push_back(r);
    r.bits = 64'h3FF0000000000000; r.want = mk(0, 1023, 0, 0, ST_OK);
    table_rows.push_back(r);
    r.bits = 64'hFFF0000000000000; r.want = mk(1, 2046, 24'hFFFFF, 32'hFFFFFFFF,
                                               ST_OVERFLOW);
    table_rows.push_back(r);
    r.bits = 64'h7FF8000000000001; r.want = mk(0, 2046, 24'hFFFFF, 32'hFFFFFFFF,
                                               ST_OVERFLOW);
    table_rows.push_back(r);
    r.bits = 64'h7FEFFFFFFFFFFFFF; r.want = mk(0, 2046, 24'hFFFFF, 32'hFFFFFFFF, ST_OK);
    table_rows.push_back(r);
    r.typed = 0;
    r.bits = 64'h0000000000000001; table_rows.push_back(r);
    r.bits = 64'h800FFFFFFFFFFFFF; table_rows.push_back(r);
    r.bits = 64'h0010000000000000; table_rows.push_back(r);
    r.bits = 64'hC00921FB54442D18; table_rows.push_back(r);
    foreach (table_rows[i])
      send_word(table_rows[i].bits,
                table_rows[i].typed ? table_rows[i].want
                                    : convert_double(table_rows[i].bits, cur_fmt));

    // The same table in the other formats, plus ignored codes in between.
    codes = '{3'd0, 3'd5, 3'd2, 3'd3, 3'd7, 3'd4, 3'd6};
    foreach (codes[c]) begin
      write_format(codes[c]);
      foreach (table_rows[i]) send_predicted(table_rows[i].bits);
    end
    // Boundary values of the narrow formats.
    send_predicted(64'h47EFFFFFE0000000);
    send_predicted(64'h47F0000000000000);
    send_predicted(64'h3810000000000000);
    send_predicted(64'h380FFFFFFFFFFFFF);

    // Random phases over the formats, with a calm stretch in the middle.
    for (int ph = 0; ph < 10; ph++) begin
      write_format(ph == 9 ? 3'd1 : 3'($urandom_range(7)));
      calm = (ph == 5);
      for (int n = 0; n < 120; n++) begin
        send_predicted(pick_double());
        if (ph == 3 && n == 60) drain();
      end
    end
    calm = 1'b0;

    drain();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
